>>> src/index_pool_allocator_macros.svh
// Assertion macros shared by the allocator sources.
`ifndef INDEX_POOL_ALLOCATOR_MACROS_SVH
`define INDEX_POOL_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define IPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

>>> src/ipa_pkg.sv
package ipa_pkg;

    localparam int REL_W       = 8;
    localparam int GRANT_W     = 9;
    localparam int LIMIT_W     = 9;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_NOT_IN_USE = 2'd2
    } t_status;

endpackage

>>> src/ipa_ram.sv
module ipa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read of the address written in the same cycle returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/index_pool_allocator.sv
// Index pool allocator.
// Requests arrive on the s_axis channel: tuser carries the opcode (allocate or
// release) and tdata the index to release. Each request gives exactly one word
// on the m_axis channel: tdata holds the granted index (the effective limit
// when the pool is exhausted, zero for a release) and tuser the status.
// An allocation reuses the oldest released index first, then hands out the
// next never-used index below the limit written on the configuration port.
// A request is accepted into an input register and its answer is captured in a
// result register once that register is empty or being taken; one request per
// cycle is sustained while m_axis_tready stays high.
// The free queue is a RAM whose read port always prefetches the next head
// entry, with a one-word bypass for a push onto the entry being read, so a
// pop never waits. The in-use bitmap lives in flip-flops cleared by reset; the
// bit for a request is looked up as the request is accepted.
// Reset empties the queue and bitmap, rewinds the fresh counter and sets the
// limit to 256; no clearing pass is needed. When m_axis_tready is low the
// result holds, one more request is taken into the input register, and then
// s_axis_tready drops until the result is taken.
module index_pool_allocator #(
    parameter int POOL_SIZE = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ipa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] release_index
    input  logic [0:0]                    s_axis_tuser,  // [0] opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ipa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [8:0] granted_index, zero fill
    output logic [ipa_pkg::STATUS_W-1:0]  m_axis_tuser,  // [1:0] status
    input  logic                          i_cfg_we,
    input  logic [ipa_pkg::LIMIT_W-1:0]   i_cfg_wdata
);

    import ipa_pkg::*;

    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam int CNT_W = $clog2(POOL_SIZE + 1);
    localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [LIM_W-1:0] POOL_W   = LIM_W'(POOL_SIZE);
    localparam logic [IDX_W-1:0] LAST_PTR = IDX_W'(POOL_SIZE - 1);
    localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SIZE);

    logic                 r_in_valid;
    t_opcode              r_in_op;
    logic [REL_W-1:0]     r_in_rel;
    logic                 r_in_used;
    logic                 r_out_valid;
    logic [GRANT_W-1:0]   r_out_granted;
    t_status              r_out_status;

    logic [LIMIT_W-1:0]   r_limit;
    logic [IDX_W-1:0]     r_head;
    logic [IDX_W-1:0]     r_tail;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_next_fresh;
    logic [POOL_SIZE-1:0] r_map;
    logic                 r_byp_hit;
    logic [IDX_W-1:0]     r_byp_data;

    logic [IDX_W-1:0]     n_head;
    logic [IDX_W-1:0]     n_tail;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     n_next_fresh;

    logic                 proceed;
    logic [LIM_W-1:0]     lim;
    logic [LIM_W-1:0]     limit_wide;
    logic [LIM_W-1:0]     rel_wide;
    logic [IDX_W-1:0]     rel_idx;
    logic [LIM_W-1:0]     acc_wide;
    logic [IDX_W-1:0]     acc_idx;
    logic                 acc_used;
    logic [IDX_W-1:0]     ram_q;
    logic [IDX_W-1:0]     head_data;
    logic [LIM_W-1:0]     granted;
    t_status              status;
    logic                 push;
    logic                 map_set;
    logic                 map_clr;
    logic [IDX_W-1:0]     map_addr;
    logic                 rel_ok;
    logic                 fresh_ok;

    assign proceed       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proceed;

    assign limit_wide = LIM_W'(r_limit);
    assign lim        = (limit_wide > POOL_W) ? POOL_W : limit_wide;
    assign rel_wide   = LIM_W'(r_in_rel);
    assign rel_idx    = rel_wide[IDX_W-1:0];
    assign head_data  = r_byp_hit ? r_byp_data : ram_q;

    assign acc_wide = LIM_W'(s_axis_tdata[REL_W-1:0]);
    assign acc_idx  = acc_wide[IDX_W-1:0];
    // A bitmap bit written on this edge is forwarded to the request being accepted.
    assign acc_used = ((map_set || map_clr) && map_addr == acc_idx) ? map_set : r_map[acc_idx];

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_next_fresh = r_next_fresh;
        granted      = '0;
        status       = ST_OK;
        push         = 1'b0;
        map_set      = 1'b0;
        map_clr      = 1'b0;
        map_addr     = rel_idx;
        if (proceed) begin
            unique case (r_in_op)
                OP_ALLOC: begin
                    priority if (r_count != '0) begin
                        granted  = LIM_W'(head_data);
                        n_head   = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
                        n_count  = r_count - 1'b1;
                        map_set  = 1'b1;
                        map_addr = head_data;
                    end else if (LIM_W'(r_next_fresh) < lim) begin
                        granted      = LIM_W'(r_next_fresh);
                        n_next_fresh = r_next_fresh + 1'b1;
                        map_set      = 1'b1;
                        map_addr     = r_next_fresh[IDX_W-1:0];
                    end else begin
                        granted = lim;
                        status  = ST_EXHAUSTED;
                    end
                end
                OP_RELEASE: begin
                    if (rel_wide < POOL_W && r_in_used) begin
                        map_clr = 1'b1;
                        if (r_count < POOL_CNT) begin
                            push    = 1'b1;
                            n_tail  = (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        status = ST_NOT_IN_USE;
                    end
                end
                default: begin
                    status = ST_OK;
                end
            endcase
        end
    end

    // The read port always fetches the entry that will be the head next cycle.
    ipa_ram #(
        .WIDTH(IDX_W),
        .DEPTH(POOL_SIZE)
    ) u_free_queue (
        .i_clk  (i_clk),
        .i_we   (push),
        .i_waddr(r_tail),
        .i_wdata(rel_idx),
        .i_raddr(n_head),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_limit      <= LIMIT_RESET;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_next_fresh <= '0;
            r_map        <= '0;
            r_byp_hit    <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (proceed) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_next_fresh <= n_next_fresh;
            if (map_set) begin
                r_map[map_addr] <= 1'b1;
            end else if (map_clr) begin
                r_map[map_addr] <= 1'b0;
            end
            // A push onto the entry being prefetched is caught here.
            r_byp_hit <= push && (r_tail == n_head);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= t_opcode'(s_axis_tuser[0]);
            r_in_rel  <= s_axis_tdata[REL_W-1:0];
            r_in_used <= acc_used;
        end
        if (proceed) begin
            r_out_granted <= granted[GRANT_W-1:0];
            r_out_status  <= status;
        end
        r_byp_data <= rel_idx;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_granted);
    assign m_axis_tuser  = r_out_status;

    assign rel_ok   = proceed && r_in_op == OP_RELEASE && status == ST_OK;
    assign fresh_ok = proceed && r_in_op == OP_ALLOC && r_count == '0 && status == ST_OK;

`include "index_pool_allocator_macros.svh"

    `IPA_ASSERT_SAME(a_queued_not_in_use, i_clk, i_rst_n, r_count != '0, !r_map[head_data])
    `IPA_ASSERT_NEXT(a_release_pushes, i_clk, i_rst_n, rel_ok, r_count == $past(r_count) + 1'b1)
    `IPA_ASSERT_NEXT(a_fresh_inc, i_clk, i_rst_n, fresh_ok, r_next_fresh == $past(r_next_fresh) + 1'b1)
    `IPA_ASSERT_NEXT(a_fresh_marked, i_clk, i_rst_n, fresh_ok, r_map[$past(map_addr)])

endmodule

>>> bench/index_pool_allocator_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels and the configuration port of the allocator.
// It keeps its own copy of the pool state and compares every result word.
module index_pool_allocator_checker
    import ipa_pkg::*;
#(
    parameter int POOL_SIZE = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  logic [IN_TDATA_W-1:0]  i_req_data,   // [7:0] release_index
    input  logic [0:0]             i_req_user,   // [0] opcode
    input  logic                   i_rsp_valid,
    input  logic                   i_rsp_ready,
    input  logic [OUT_TDATA_W-1:0] i_rsp_data,   // [8:0] granted_index, zero fill
    input  logic [STATUS_W-1:0]    i_rsp_user,   // [1:0] status
    input  logic                   i_cfg_we,
    input  logic [LIMIT_W-1:0]     i_cfg_wdata,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_results,
    output int                     o_exhausted,
    output int                     o_rejected
);

    typedef struct packed {
        logic [GRANT_W-1:0] grant;
        t_status            status;
    } t_answer;

    t_answer            answer_q[$];
    logic [REL_W-1:0]   free_ring [POOL_SIZE];
    bit                 busy_map [POOL_SIZE];
    int                 ring_head;
    int                 ring_tail;
    int                 ring_count;
    int                 fresh_next;
    logic [LIMIT_W-1:0] limit_reg;
    int                 errors;
    int                 results;
    int                 exhausted;
    int                 rejected;

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_results   = 0;
        o_exhausted = 0;
        o_rejected  = 0;
        errors      = 0;
        results     = 0;
        exhausted   = 0;
        rejected    = 0;
    end

    // Works out the answer to one request and updates the pool copy.
    function automatic t_answer serve_request(t_opcode op, logic [REL_W-1:0] idx);
        t_answer ans;
        int      cap;
        ans.grant  = '0;
        ans.status = ST_OK;
        cap = (int'(limit_reg) > POOL_SIZE) ? POOL_SIZE : int'(limit_reg);
        if (op == OP_ALLOC) begin
            if (ring_count > 0) begin
                // Released indices are reused first, even above a lowered limit.
                ans.grant = GRANT_W'(free_ring[ring_head]);
                ring_head = (ring_head + 1) % POOL_SIZE;
                ring_count--;
                busy_map[ans.grant] = 1'b1;
            end else if (fresh_next < cap) begin
                ans.grant = GRANT_W'(fresh_next);
                fresh_next++;
                busy_map[ans.grant] = 1'b1;
            end else begin
                ans.grant  = GRANT_W'(cap);
                ans.status = ST_EXHAUSTED;
            end
        end else if (int'(idx) < POOL_SIZE && busy_map[idx]) begin
            busy_map[idx] = 1'b0;
            if (ring_count < POOL_SIZE) begin
                free_ring[ring_tail] = idx;
                ring_tail = (ring_tail + 1) % POOL_SIZE;
                ring_count++;
            end
        end else begin
            ans.status = ST_NOT_IN_USE;
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            answer_q.delete();
            for (int k = 0; k < POOL_SIZE; k++) begin
                busy_map[k] = 1'b0;
            end
            ring_head  = 0;
            ring_tail  = 0;
            ring_count = 0;
            fresh_next = 0;
            limit_reg  = LIMIT_RESET;
        end else begin
            // A result word always belongs to an earlier request, so pop first.
            if (i_rsp_valid && i_rsp_ready) begin
                results++;
                if (answer_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word, granted_index %0d status %0d",
                             $time, i_rsp_data[GRANT_W-1:0], i_rsp_user);
                end else begin
                    want = answer_q.pop_front();
                    if (want.status == ST_EXHAUSTED) exhausted++;
                    if (want.status == ST_NOT_IN_USE) rejected++;
                    if (i_rsp_data[GRANT_W-1:0] !== want.grant) begin
                        errors++;
                        $display("%0t: granted_index expected %0d, actual %0d",
                                 $time, want.grant, i_rsp_data[GRANT_W-1:0]);
                    end
                    if (i_rsp_user !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, i_rsp_user);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                answer_q.insert(answer_q.size(),
                                serve_request(t_opcode'(i_req_user[0]), i_req_data));
            end
            if (i_cfg_we) begin
                limit_reg = i_cfg_wdata;
            end
        end
        o_pending   <= answer_q.size();
        o_errors    <= errors;
        o_results   <= results;
        o_exhausted <= exhausted;
        o_rejected  <= rejected;
    end

endmodule

>>> bench/index_pool_allocator_tb.sv
`timescale 1ns / 100ps

module index_pool_allocator_tb;
    import ipa_pkg::*;

    localparam int POOL      = 256;
    localparam int LONG_HOLD = 80;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] release_index
    logic [0:0]             s_axis_tuser;   // [0] opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [8:0] granted_index, zero fill
    logic [STATUS_W-1:0]    m_axis_tuser;   // [1:0] status
    logic                   i_cfg_we;
    logic [LIMIT_W-1:0]     i_cfg_wdata;

    int errors;
    int pending;
    int results;
    int exhausted;
    int rejected;
    int sent;
    int settings;
    int holds_done;
    int alloc_reach;
    bit quiet;
    bit hold_off;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    index_pool_allocator #(
        .POOL_SIZE(POOL)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    index_pool_allocator_checker #(
        .POOL_SIZE(POOL)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_data  (m_axis_tdata),
        .i_rsp_user  (m_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_exhausted (exhausted),
        .o_rejected  (rejected)
    );

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    task automatic post_request(input t_opcode op, input logic [REL_W-1:0] idx);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= idx;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
        if (op == OP_ALLOC && alloc_reach < POOL - 1) alloc_reach++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // The limit is only changed once every result word has come back.
    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] value, input int count,
                             input int alloc_pct, input bit no_gaps, input bit stall);
        t_opcode          op;
        logic [REL_W-1:0] idx;
        set_limit(value);
        quiet = no_gaps;
        if (stall) hold_off = 1'b1;
        repeat (count) begin
            op = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_RELEASE;
            // Releases mostly aim at indices that may have been handed out.
            if (op == OP_RELEASE && $urandom_range(99) < 80)
                idx = REL_W'($urandom_range(alloc_reach));
            else
                idx = REL_W'($urandom_range(POOL - 1));
            post_request(op, idx);
        end
        quiet = 1'b0;
    endtask

    initial begin
        m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                // Long hold so the block fills up and drops s_axis_tready.
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_off = 1'b0;
                holds_done++;
            end else begin
                int gap;
                gap = pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        sent        = 0;
        settings    = 0;
        holds_done  = 0;
        alloc_reach = 0;
        quiet       = 1'b0;
        hold_off    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Releases of indices nobody holds, at both ends of the range.
        post_request(OP_RELEASE, 8'd0);
        post_request(OP_RELEASE, 8'hFF);
        // Tiny pool: fill it, run dry, and reuse in release order.
        set_limit(9'd2);
        post_request(OP_ALLOC, 8'hFF);
        post_request(OP_ALLOC, 8'd0);
        post_request(OP_ALLOC, 8'hAA);
        post_request(OP_RELEASE, 8'd1);
        post_request(OP_RELEASE, 8'd0);
        post_request(OP_ALLOC, 8'd0);
        post_request(OP_ALLOC, 8'h55);
        post_request(OP_ALLOC, 8'd0);
        post_request(OP_RELEASE, 8'd1);
        post_request(OP_RELEASE, 8'd1);
        // A zero limit still hands out queued indices.
        set_limit(9'd0);
        post_request(OP_ALLOC, 8'd0);
        post_request(OP_ALLOC, 8'hFF);
        // A limit above the pool saturates; then a lowered limit keeps the queue.
        set_limit(9'd511);
        post_request(OP_ALLOC, 8'd0);
        post_request(OP_RELEASE, 8'd2);
        set_limit(9'd1);
        post_request(OP_ALLOC, 8'd0);
        post_request(OP_ALLOC, 8'd0);
        alloc_reach = 3;

        run_phase(9'd8,   120, 60, 1'b0, 1'b0);
        run_phase(9'd40,  150, 65, 1'b0, 1'b1);
        run_phase(9'd0,    80, 40, 1'b0, 1'b0);
        run_phase(9'd128, 170, 70, 1'b0, 1'b0);
        run_phase(9'd300, 170, 75, 1'b1, 1'b0);
        run_phase(9'd511, 150, 60, 1'b0, 1'b1);
        run_phase(9'd1,   100, 50, 1'b0, 1'b0);
        run_phase(9'd256, 200, 55, 1'b0, 1'b0);
        run_phase(9'd2,    80, 45, 1'b0, 1'b0);
        run_phase(9'd200, 180, 50, 1'b1, 1'b0);
        run_phase(9'd256, 230, 50, 1'b0, 1'b0);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        $display("Sent %0d requests over %0d limit settings, checked %0d result words.",
                 sent, settings, results);
        $display("Saw %0d exhausted answers, %0d rejected releases, %0d long receiver holds.",
                 exhausted, rejected, holds_done);
        if (errors == 0)
            $display("index_pool_allocator_tb: done, clean");
        else
            $display("index_pool_allocator_tb: done, errors");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("Timed out with %0d result words still outstanding.", pending);
        $display("index_pool_allocator_tb: done, errors");
        $finish;
    end

endmodule
